>>> design/smr_pkg.sv
// ----------------------------------------------------------------------------
// smr_pkg
// constants and types for the scalar reduce / multiply-add block
// ----------------------------------------------------------------------------
package smr_pkg;
   localparam int LimbW = 64;
   localparam int StoreN = 12;
   localparam int WorkW = 512;
   localparam logic [255:0] OrderL =
      256'h1000000000000000_0000000000000000_14def9dea2f79cd6_5812631a5cf5d3ed;
   localparam logic [1:0] FuncReduce = 2'd0;

   typedef enum logic [2:0] {
      ST_LOAD, ST_MUL, ST_ADDC, ST_SCAN, ST_SUB, ST_OUT
   } state_type;
endpackage

>>> design/scalar_muladd_reduce_mod_order.sv
// ----------------------------------------------------------------------------
// scalar_muladd_reduce_mod_order
// scalar reduction mod the ed25519 group order, with multiply-add mode
// ----------------------------------------------------------------------------
// req channel: one 64-bit operand limb per item, least significant first;
// tuser bit 0 selects the operation (0 reduce, 1 a*b+c), read on the item
// with tlast, which starts the job. missing limbs count as zero, limbs past
// the twelfth are dropped. while in load, one limb item is taken per cycle.
// rsp channel: four result limbs per job, index in tuser, tlast on the last.
// after the tlast item, multiply-add runs 16 limb products on one
// 32x32 multiplier, four partial products each, then adds the four c
// limbs; reduce skips both. a scan from limb 7 down finds the top limb,
// then compare-subtract steps run on one 512-bit subtractor
// (top bit minus 251 steps, up to 260, none below bit 252), then the
// four result limbs go out; the rsp side can stall the output.
// req_tready is low after the job end item is taken until the last result is taken.
// reset clears the limb count, the operand store and the sequencer.
// a stalled rsp side holds the current result limb.
// ----------------------------------------------------------------------------
module scalar_muladd_reduce_mod_order import smr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // data_word
   input  logic        req_tuser,   // func
   input  logic        req_tlast,   // job_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // result_word
   output logic [1:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast    // final_word
);
   state_type state_ff, state_in;
   logic [LimbW-1:0] store_ff [StoreN];
   logic [3:0] cnt_ff, cnt_in;
   logic [WorkW-1:0] work_ff, work_in;
   logic [1:0] step_ff, step_in;
   logic [9:0] sh_ff, sh_in;
   logic [2:0] scan_ff, scan_in;

   logic accept;
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_LOAD);

   // multiply: cnt = {i,j} limb pair, step = half-select pair
   logic [1:0] mq;
   logic [31:0] ma, mb;
   logic [639:0] addend;
   logic [3:0] pidx;
   assign pidx = cnt_ff;
   assign mq = step_ff;
   logic [1:0] pa, pb;
   assign pa = pidx[3:2];
   assign pb = pidx[1:0];
   assign ma = mq[1] ? store_ff[pa][63:32] : store_ff[pa][31:0];
   assign mb = mq[0] ? store_ff[4+pb][63:32] : store_ff[4+pb][31:0];

   logic [9:0] pos;
   assign pos = ({7'd0, pa} + {7'd0, pb}) * 10'd64
                + {3'd0, {1'b0, mq[1]} + {1'b0, mq[0]}, 5'd0};

   logic [WorkW-1:0] shl, diff;
   logic borrow;
   assign shl = {256'd0, OrderL} << sh_ff;
   assign {borrow, diff} = {1'b0, work_ff} - {1'b0, shl};

   logic [63:0] scan_limb;
   assign scan_limb = work_ff[scan_ff*64 +: 64];
   logic [5:0] msb;
   always_comb begin
      msb = '0;
      for (int k = 0; k < 64; k++) if (scan_limb[k]) msb = 6'(k);
   end
   logic [9:0] topb;
   assign topb = {1'b0, scan_ff, msb};

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; work_in = work_ff;
      step_in = step_ff; sh_in = sh_ff; scan_in = scan_ff;
      addend = '0;
      unique case (state_ff)
         ST_LOAD: if (accept) begin
            if (cnt_ff < 4'(StoreN)) cnt_in = cnt_ff + 4'd1;
            if (req_tlast) begin
               cnt_in = '0; step_in = '0;
               if (req_tuser == FuncReduce[0]) begin
                  state_in = ST_SCAN; scan_in = 3'd7;
                  for (int k = 0; k < 8; k++)
                     work_in[k*64 +: 64] = (cnt_ff == 4'(k)) ? req_tdata : store_ff[k];
               end else begin
                  state_in = ST_MUL; work_in = '0;
               end
            end
         end
         ST_MUL: begin
            addend[pos +: 64] = {32'd0, ma} * {32'd0, mb};
            work_in = work_ff + addend[WorkW-1:0];
            step_in = step_ff + 2'd1;
            if (mq == 2'd3) begin
               step_in = '0;
               cnt_in = cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin state_in = ST_ADDC; cnt_in = '0; end
            end
         end
         ST_ADDC: begin
            addend[{cnt_ff[1:0], 6'd0} +: 64] = store_ff[8 + cnt_ff[1:0]];
            work_in = work_ff + addend[WorkW-1:0];
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin state_in = ST_SCAN; scan_in = 3'd7; cnt_in = '0; end
         end
         ST_SCAN: begin
            if (scan_limb != '0) begin
               if (topb >= 10'd252) begin sh_in = topb - 10'd252; state_in = ST_SUB; end
               else begin state_in = ST_OUT; cnt_in = '0; end
            end else if (scan_ff == 3'd0) begin state_in = ST_OUT; cnt_in = '0; end
            else scan_in = scan_ff - 3'd1;
         end
         ST_SUB: begin
            if (!borrow) work_in = diff;
            if (sh_ff == '0) begin state_in = ST_OUT; cnt_in = '0; end
            else sh_in = sh_ff - 10'd1;
         end
         ST_OUT: if (rsp_tready) begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin state_in = ST_LOAD; cnt_in = '0; end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; cnt_ff <= '0;
         for (int k = 0; k < StoreN; k++) store_ff[k] <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in;
         if (accept && cnt_ff < 4'(StoreN)) store_ff[cnt_ff] <= req_tdata;
         if (state_ff == ST_OUT && rsp_tready && cnt_ff == 4'd3)
            for (int k = 0; k < StoreN; k++) store_ff[k] <= '0;
      end
      work_ff <= work_in; step_ff <= step_in;
      sh_ff <= sh_in; scan_ff <= scan_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = work_ff[cnt_ff[1:0]*64 +: 64];
   assign rsp_tuser = cnt_ff[1:0];
   assign rsp_tlast = (cnt_ff[1:0] == 2'd3);
endmodule
